@@ rtl/gps_link_autobaud_supervisor_defines.svh @@
// Assertion macros shared by the link supervisor RTL.
`ifndef GPS_LINK_AUTOBAUD_SUPERVISOR_DEFINES_SVH
`define GPS_LINK_AUTOBAUD_SUPERVISOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property outside reset.
`define GLAS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("glas assertion failed");

// Check a property at every edge, reset included.
`define GLAS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("glas assertion failed");

`else

`define GLAS_ASSERT(lbl, clk, rstn, prop)
`define GLAS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/glas_pkg.sv @@
// Types, codes and helpers of the GPS link autobaud supervisor.
`timescale 1ns / 1ps
`default_nettype none

package glas_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned BaudW   = 3;

  localparam logic [BaudW-1:0]   BaudMax         = 3'd6;
  localparam logic [BaudW-1:0]   BaudUnknownNext = 3'd1;
  localparam logic [BaudW-1:0]   BaudReset       = 3'd1;
  localparam logic [PeriodW-1:0] WatchdogReset   = 16'd5000;
  localparam logic [PeriodW-1:0] InhibitReset    = 16'd3000;
  localparam logic [PeriodW-1:0] TestReset       = 16'd327;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_TEST   = 2'd1,
    CMD_BAUD   = 2'd2,
    CMD_ENABLE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_STOPPED = 2'd1,
    EDGE_STARTED = 2'd2
  } edge_e;

  typedef enum logic [1:0] {
    REG_WATCHDOG = 2'd0,
    REG_INHIBIT  = 2'd1,
    REG_TEST     = 2'd2,
    REG_TARGET   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             had_message;
    logic             time_msgs_missing;
    logic             fix_msgs_missing;
  } in_t;

  typedef struct packed {
    cmd_e             command;
    logic             set_baud;
    logic [BaudW-1:0] baud_index;
    logic             link_stopped;
    edge_e            link_edge;
  } out_t;

  typedef struct packed {
    logic [PeriodW-1:0] msg_timeout_ms;
    logic [PeriodW-1:0] inhibit_period_ms;
    logic [PeriodW-1:0] test_period_ms;
    logic [BaudW-1:0]   target_baud_index;
  } cfg_t;

  // True once period ms have gone by since stamp, modulo 2^32.
  function automatic logic elapsed(input logic [TimeW-1:0]   now,
                                   input logic [TimeW-1:0]   stamp,
                                   input logic [PeriodW-1:0] period);
    logic [TimeW-1:0] diff;
    diff = now - stamp;
    return diff >= {{(TimeW-PeriodW){1'b0}}, period};
  endfunction

  // Next rate in the search cycle, wrapping from the top index to 0; an unknown index falls back to index 1.
  function automatic logic [BaudW-1:0] step_baud(input logic [BaudW-1:0] b);
    logic [BaudW-1:0] nxt;
    if (b < BaudMax) begin
      nxt = b + 3'd1;
    end else if (b == BaudMax) begin
      nxt = '0;
    end else begin
      nxt = BaudUnknownNext;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/glas_if.sv @@
// Request channels of the link supervisor: poll input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface glas_in_if;
  logic           valid;
  logic           ready;
  glas_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface glas_out_if;
  logic           valid;
  logic           ready;
  glas_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface glas_cfg_if;
  logic                 valid;
  logic                 ready;
  glas_pkg::cfg_reg_e   index;
  logic [15:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/gps_link_autobaud_supervisor.sv @@
// Top level of the GPS link autobaud supervisor.
// One poll request (time, message flags) yields one result request (command,
// rate change, rate index, link state and edge). Each poll passes a poll
// register and then a result register, so with the output free its result is
// valid from the clock edge after acceptance, and a new poll may be accepted
// every clock cycle. While a result waits to be taken, the poll register holds
// one further poll and then the input stalls until the result is taken.
// Configuration writes are always accepted and take effect on the next cycle;
// write them only while no poll is in flight.
`timescale 1ns / 1ps
`default_nettype none

module gps_link_autobaud_supervisor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  glas_in_if.sink    in_i,
  glas_out_if.source res_o,
  glas_cfg_if.sink   cfg_i
);

  glas_pkg::cfg_t cfg;

  // Hold the configuration registers
  glas_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Run the supervisor on each poll
  glas_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

@@ rtl/glas_cfg.sv @@
// Configuration register file of the link supervisor.
`timescale 1ns / 1ps
`default_nettype none
`include "gps_link_autobaud_supervisor_defines.svh"

module glas_cfg (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  glas_cfg_if.sink     cfg_i,
  output glas_pkg::cfg_t cfg_o
);

  glas_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write request
  assign cfg_i.ready = 1'b1;

  // Decode the write; saturate the target rate at the top index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        glas_pkg::REG_WATCHDOG: cfg_d.msg_timeout_ms    = cfg_i.data;
        glas_pkg::REG_INHIBIT:  cfg_d.inhibit_period_ms = cfg_i.data;
        glas_pkg::REG_TEST:     cfg_d.test_period_ms    = cfg_i.data;
        glas_pkg::REG_TARGET: begin
          cfg_d.target_baud_index = (cfg_i.data[2:0] > glas_pkg::BaudMax) ?
                                    glas_pkg::BaudMax : cfg_i.data[2:0];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msg_timeout_ms    <= glas_pkg::WatchdogReset;
      cfg_q.inhibit_period_ms <= glas_pkg::InhibitReset;
      cfg_q.test_period_ms    <= glas_pkg::TestReset;
      cfg_q.target_baud_index <= glas_pkg::BaudReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  `GLAS_ASSERT(a_target_sat, clk_i, rst_ni, (cfg_q.target_baud_index <= glas_pkg::BaudMax))

endmodule

`default_nettype wire

@@ rtl/glas_core.sv @@
// Poll register, supervisor state and result register of the link supervisor.
`timescale 1ns / 1ps
`default_nettype none
`include "gps_link_autobaud_supervisor_defines.svh"

module glas_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  glas_pkg::cfg_t cfg_i,
  glas_in_if.sink        in_i,
  glas_out_if.source     res_o
);

  // Poll register
  logic           in_valid_q, in_valid_d;
  glas_pkg::in_t  in_q, in_d;
  // Result register
  logic           out_valid_q, out_valid_d;
  glas_pkg::out_t out_q, out_d;
  // Supervisor state
  logic [glas_pkg::TimeW-1:0] wd_stamp_q, wd_stamp_d;
  logic [glas_pkg::TimeW-1:0] inh_stamp_q, inh_stamp_d;
  logic [glas_pkg::TimeW-1:0] test_stamp_q, test_stamp_d;
  logic                       was_stopped_q, was_stopped_d;
  logic                       inhibited_q, inhibited_d;
  logic [glas_pkg::BaudW-1:0] baud_q, baud_d;

  logic advance;
  logic step;
  logic stopped;
  logic inhibit_open;

  // The result register frees when empty or taken; the poll register follows
  assign advance     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Load the poll register
  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_i.ready) begin
      in_valid_d = in_i.valid;
      in_d       = in_i.data;
    end
  end

  // Work out one poll: watchdog, inhibit window, then at most one action
  always_comb begin
    wd_stamp_d    = wd_stamp_q;
    inh_stamp_d   = inh_stamp_q;
    test_stamp_d  = test_stamp_q;
    was_stopped_d = was_stopped_q;
    inhibited_d   = inhibited_q;
    baud_d        = baud_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;

    if (in_q.had_message) begin
      wd_stamp_d = in_q.now_ms;
    end
    stopped = glas_pkg::elapsed(in_q.now_ms, wd_stamp_d, cfg_i.msg_timeout_ms);
    inhibit_open = glas_pkg::elapsed(in_q.now_ms, inh_stamp_q, cfg_i.inhibit_period_ms);

    out_d.command      = glas_pkg::CMD_NONE;
    out_d.set_baud     = 1'b0;
    out_d.link_stopped = stopped;
    if (stopped && !was_stopped_q) begin
      out_d.link_edge = glas_pkg::EDGE_STOPPED;
    end else if (!stopped && was_stopped_q) begin
      out_d.link_edge = glas_pkg::EDGE_STARTED;
    end else begin
      out_d.link_edge = glas_pkg::EDGE_NONE;
    end
    was_stopped_d = stopped;
    inhibited_d   = inhibited_q && !inhibit_open;

    priority if (inhibited_d) begin
      if (stopped &&
          glas_pkg::elapsed(in_q.now_ms, test_stamp_q, cfg_i.test_period_ms)) begin
        test_stamp_d  = in_q.now_ms;
        out_d.command = glas_pkg::CMD_TEST;
      end
    end else if (stopped) begin
      inh_stamp_d    = in_q.now_ms;
      inhibited_d    = 1'b1;
      baud_d         = glas_pkg::step_baud(baud_q);
      out_d.set_baud = 1'b1;
      out_d.command  = glas_pkg::CMD_TEST;
    end else if (baud_q != cfg_i.target_baud_index) begin
      inh_stamp_d    = in_q.now_ms;
      inhibited_d    = 1'b1;
      baud_d         = cfg_i.target_baud_index;
      out_d.set_baud = 1'b1;
      out_d.command  = glas_pkg::CMD_BAUD;
    end else if (in_q.time_msgs_missing || in_q.fix_msgs_missing) begin
      inh_stamp_d   = in_q.now_ms;
      inhibited_d   = 1'b1;
      out_d.command = glas_pkg::CMD_ENABLE;
    end else begin
      out_d.command = glas_pkg::CMD_NONE;
    end
    out_d.baud_index = baud_d;

    // Commit only when the poll moves into the result register
    if (!step) begin
      wd_stamp_d    = wd_stamp_q;
      inh_stamp_d   = inh_stamp_q;
      test_stamp_d  = test_stamp_q;
      was_stopped_d = was_stopped_q;
      inhibited_d   = inhibited_q;
      baud_d        = baud_q;
      out_d         = out_q;
    end
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      wd_stamp_q    <= '0;
      inh_stamp_q   <= '0;
      test_stamp_q  <= '0;
      was_stopped_q <= 1'b1;
      inhibited_q   <= 1'b1;
      baud_q        <= glas_pkg::BaudReset;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      wd_stamp_q    <= wd_stamp_d;
      inh_stamp_q   <= inh_stamp_d;
      test_stamp_q  <= test_stamp_d;
      was_stopped_q <= was_stopped_d;
      inhibited_q   <= inhibited_d;
      baud_q        <= baud_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  `GLAS_ASSERT(a_setb_cmd, clk_i, rst_ni,
               (out_valid_q && out_q.set_baud |->
                (out_q.command == glas_pkg::CMD_TEST || out_q.command == glas_pkg::CMD_BAUD)))
  `GLAS_ASSERT(a_baud_hold, clk_i, rst_ni, (!step |=> $stable(baud_q)))
  `GLAS_ASSERT(a_edge_match, clk_i, rst_ni,
               (step |=> (out_q.link_stopped == was_stopped_q)))
  `GLAS_ASSERT_ALWAYS(a_baud_range, clk_i, (baud_q <= glas_pkg::BaudMax))

endmodule

`default_nettype wire
